// ===== rtl/core/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 to code point decoder.
`default_nettype none
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int PART_W = 15;
    localparam int LEFT_W = 2;
    localparam int CONT_W = 6;

    localparam logic [BYTE_W-1:0] LINE_FEED = 8'h0A;

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    typedef struct packed {
        logic [LEFT_W-1:0] bytes_left;
        logic [PART_W-1:0] partial_value;
        logic              skipping_line;
    } t_dec_state;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            decode_error;
        logic            line_end;
    } t_dec_result;

endpackage
`default_nettype wire

// ===== rtl/core/utf8_to_codepoint_decoder.sv =====
// UTF-8 byte stream to code point decoder, top level.
//
// Input channel: one UTF-8 byte per transaction (i_in_valid / o_in_ready).
// Output channel: one code point per completed sequence (o_out_valid /
// i_out_ready), with o_decode_error for a malformed byte and o_line_end
// on a newline. An error drops the rest of the line through the next
// newline; those bytes produce no transaction.
// Throughput: one byte per cycle unless the output stalls. The input
// register feeds the per-byte decode logic, which updates the sequence
// state and loads the result register in the same cycle, so every byte
// takes exactly one pass, from the input register to the result register.
// Stall: while the result register is full and i_out_ready is low, the
// input register holds and o_in_ready drops once it is occupied.
// Reset: synchronous, active low; clears both registers' valid flags and
// the sequence state (no bytes pending, no line being dropped).
`default_nettype none
module utf8_to_codepoint_decoder
    import u8d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [CP_W-1:0]        o_code_point,
    output logic                   o_decode_error,
    output logic                   o_line_end
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_dec_state        r_state;
    logic              r_out_valid;
    t_dec_result       r_out;

    t_dec_state        n_state;
    logic              step_res_valid;
    t_dec_result       step_res;
    logic              out_free;
    logic              step_go;

    u8d_step u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign step_go    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step_go) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= step_go && step_res_valid;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
        if (step_go && step_res_valid) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_code_point   = r_out.code_point;
    assign o_decode_error = r_out.decode_error;
    assign o_line_end     = r_out.line_end;

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_decode_error |-> o_code_point == '0 && !o_line_end)
        else $error("error result carries data");

    a_eol_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end |-> o_code_point == CP_W'(LINE_FEED))
        else $error("line end on a code point other than newline");

    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skipping_line |-> r_state.bytes_left == '0)
        else $error("line drop with a sequence pending");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(r_out))
        else $error("result lost under stall");

endmodule
`default_nettype wire

// ===== rtl/core/u8d_step.sv =====
// Per-byte decode logic: next decoder state and optional result for one byte.
`default_nettype none
module u8d_step
    import u8d_pkg::*;
(
    input  wire t_dec_state        i_state,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_dec_state             o_state,
    output logic                   o_res_valid,
    output t_dec_result            o_res
);

    logic is_cont;
    logic is_lf;

    assign is_cont = (i_byte[7:6] == CONT_TAG);
    assign is_lf   = (i_byte == LINE_FEED);

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        priority if (i_state.skipping_line) begin
            if (is_lf) begin
                o_state.skipping_line = 1'b0;
            end
        end else if (i_state.bytes_left != '0) begin
            if (!is_cont) begin
                o_state.bytes_left    = '0;
                o_state.partial_value = '0;
                o_state.skipping_line = !is_lf;
                o_res_valid           = 1'b1;
                o_res.decode_error    = 1'b1;
            end else if (i_state.bytes_left == LEFT_W'(1)) begin
                o_state.bytes_left    = '0;
                o_state.partial_value = '0;
                o_res_valid           = 1'b1;
                o_res.code_point      = {i_state.partial_value, i_byte[CONT_W-1:0]};
            end else begin
                o_state.bytes_left    = i_state.bytes_left - LEFT_W'(1);
                o_state.partial_value = {i_state.partial_value[PART_W-CONT_W-1:0],
                                         i_byte[CONT_W-1:0]};
            end
        end else begin
            priority if (!i_byte[7]) begin
                o_res_valid      = 1'b1;
                o_res.code_point = {{(CP_W-BYTE_W){1'b0}}, i_byte};
                o_res.line_end   = is_lf;
            end else if (i_byte[7:5] == LEAD2_TAG) begin
                o_state.partial_value = {{(PART_W-5){1'b0}}, i_byte[4:0]};
                o_state.bytes_left    = LEFT_W'(1);
            end else if (i_byte[7:4] == LEAD3_TAG) begin
                o_state.partial_value = {{(PART_W-4){1'b0}}, i_byte[3:0]};
                o_state.bytes_left    = LEFT_W'(2);
            end else if (i_byte[7:3] == LEAD4_TAG) begin
                o_state.partial_value = {{(PART_W-3){1'b0}}, i_byte[2:0]};
                o_state.bytes_left    = LEFT_W'(3);
            end else begin
                o_state.partial_value = '0;
                o_state.skipping_line = 1'b1;
                o_res_valid           = 1'b1;
                o_res.decode_error    = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim/utf8_to_codepoint_decoder_tb.sv =====
// Self-checking testbench for the UTF-8 to code point decoder.
`timescale 1ns / 1ps
module utf8_to_codepoint_decoder_tb;
    import u8d_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int TAIL_CYCLES   = 6;

    class codepoint_checker;
        logic [LEFT_W-1:0] seq_left;
        logic [PART_W-1:0] seq_bits;
        logic              dropping_line;
        t_dec_result       expected_points[$];
        int                live_bytes;
        int                dropped_bytes;
        int                n_points;
        int                n_line_ends;
        int                n_errors;
        int                failures;

        function new();
            seq_left      = '0;
            seq_bits      = '0;
            dropping_line = 1'b0;
            live_bytes    = 0;
            dropped_bytes = 0;
            n_points      = 0;
            n_line_ends   = 0;
            n_errors      = 0;
            failures      = 0;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            t_dec_result r;
            logic        has_result;
            r          = '0;
            has_result = 1'b0;
            if (dropping_line) begin
                dropped_bytes++;
                if (b == LINE_FEED) dropping_line = 1'b0;
            end else begin
                live_bytes++;
                if (seq_left != '0) begin
                    if (b[7:6] != CONT_TAG) begin
                        seq_left       = '0;
                        seq_bits       = '0;
                        dropping_line  = (b != LINE_FEED);
                        r.decode_error = 1'b1;
                        has_result     = 1'b1;
                    end else begin
                        seq_left = seq_left - 1'b1;
                        if (seq_left == '0) begin
                            r.code_point = {seq_bits, b[CONT_W-1:0]};
                            seq_bits     = '0;
                            has_result   = 1'b1;
                        end else begin
                            seq_bits = {seq_bits[PART_W-CONT_W-1:0], b[CONT_W-1:0]};
                        end
                    end
                end else if (b[7] == 1'b0) begin
                    r.code_point = CP_W'(b);
                    r.line_end   = (b == LINE_FEED);
                    has_result   = 1'b1;
                end else if (b[7:5] == LEAD2_TAG) begin
                    seq_bits = PART_W'(b[4:0]);
                    seq_left = LEFT_W'(1);
                end else if (b[7:4] == LEAD3_TAG) begin
                    seq_bits = PART_W'(b[3:0]);
                    seq_left = LEFT_W'(2);
                end else if (b[7:3] == LEAD4_TAG) begin
                    seq_bits = PART_W'(b[2:0]);
                    seq_left = LEFT_W'(3);
                end else begin
                    seq_bits       = '0;
                    dropping_line  = 1'b1;
                    r.decode_error = 1'b1;
                    has_result     = 1'b1;
                end
            end
            if (has_result) begin
                expected_points.push_back(r);
                if (r.decode_error) n_errors++;
                else n_points++;
                if (r.line_end) n_line_ends++;
            end
        endfunction

        function void check_result(t_dec_result got);
            t_dec_result want;
            if (expected_points.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: cp=%06h err=%b eol=%b",
                             got.code_point, got.decode_error, got.line_end);
                return;
            end
            want = expected_points.pop_front();
            if (got.code_point !== want.code_point ||
                got.decode_error !== want.decode_error ||
                got.line_end !== want.line_end) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch: expected cp=%06h err=%b eol=%b, got cp=%06h err=%b eol=%b",
                             want.code_point, want.decode_error, want.line_end,
                             got.code_point, got.decode_error, got.line_end);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_in_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CP_W-1:0]   o_code_point;
    logic              o_decode_error;
    logic              o_line_end;

    codepoint_checker cp_check;
    int               cycle_count = 0;
    bit               tx_idle_on;
    bit               rx_idle_on;
    bit               long_hold_req;

    utf8_to_codepoint_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_code_point   (o_code_point),
        .o_decode_error (o_decode_error),
        .o_line_end     (o_line_end)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_dec_result got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.code_point   = o_code_point;
                got.decode_error = o_decode_error;
                got.line_end     = o_line_end;
                cp_check.check_result(got);
            end
            if (i_in_valid && o_in_ready) cp_check.note_byte(i_in_byte);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        idle_input();
        while (cp_check.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_lead(input int len);
        case (len)
            2: send_byte(8'hC0 | 8'($urandom_range(0, 31)));
            3: send_byte(8'hE0 | 8'($urandom_range(0, 15)));
            default: send_byte(8'hF0 | 8'($urandom_range(0, 7)));
        endcase
    endtask

    task automatic send_cont();
        send_byte(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    task automatic send_char();
        int len;
        len = $urandom_range(1, 4);
        if (len == 1) send_byte(8'($urandom_range(0, 127)));
        else begin
            send_lead(len);
            repeat (len - 1) send_cont();
        end
    endtask

    task automatic send_broken();
        int                kind;
        int                len;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 2);
        if (kind == 0) send_cont();
        else if (kind == 1) send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        else begin
            len = $urandom_range(2, 4);
            send_lead(len);
            repeat ($urandom_range(0, len - 2)) send_cont();
            if ($urandom_range(0, 4) == 0) b = LINE_FEED;
            else do b = 8'($urandom); while (b[7:6] == CONT_TAG);
            send_byte(b);
        end
    endtask

    task automatic send_line();
        int sel;
        int n_chars;
        int err_at;
        sel     = $urandom_range(0, 99);
        n_chars = $urandom_range(0, 12);
        err_at  = (sel >= 70 && sel < 92) ? $urandom_range(0, n_chars) : -1;
        if (sel >= 92) begin
            repeat (n_chars) send_byte(8'($urandom));
        end else begin
            for (int i = 0; i <= n_chars; i++) begin
                if (i == err_at) send_broken();
                if (i < n_chars) send_char();
            end
        end
        send_byte(LINE_FEED);
    endtask

    task automatic run_text(input int n_bytes, input bit idle);
        int target;
        tx_idle_on = idle;
        rx_idle_on = idle;
        target     = cp_check.live_bytes + n_bytes;
        while (cp_check.live_bytes < target) send_line();
    endtask

    initial begin
        logic [BYTE_W-1:0] seq[$];
        cp_check      = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = '0;
        i_out_ready   = 1'b0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        long_hold_req = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        seq = '{8'h00, 8'h7F, 8'h0A, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hF8, 8'h0A, 8'hFF,
                8'h0A, 8'hC3, 8'h41, 8'h0A, 8'hE2, 8'h0A, 8'h41};
        foreach (seq[i]) send_byte(seq[i]);
        wait_for_results();

        run_text(700, 1'b1);
        wait_for_results();

        long_hold_req = 1'b1;
        run_text(120, 1'b0);
        run_text(250, 1'b1);
        run_text(330, 1'b0);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d decoded bytes and %0d dropped bytes of rejected lines",
                 cp_check.live_bytes, cp_check.dropped_bytes);
        $display("%0d code points, %0d line ends, %0d decode errors, %0d failures, %0d cycles",
                 cp_check.n_points, cp_check.n_line_ends, cp_check.n_errors,
                 cp_check.failures, cycle_count);
        if (cp_check.failures == 0 && cp_check.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== utf8_to_codepoint_decoder.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_step.sv
rtl/core/utf8_to_codepoint_decoder.sv
sim/utf8_to_codepoint_decoder_tb.sv
